// ===== rtl/rcb_pkg.sv =====
// Package for the ROI crop and pixel binning block.
// Holds the field widths, register indexes, reset values and shared types.
// No dependencies; every other file refers to it by scoped names.
package rcb_pkg;

  localparam int PIX_W    = 16;
  localparam int SUM_W    = 24;
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int BIN_W    = 5;
  localparam int REM_W    = 4;
  localparam int REG_W    = 13;
  localparam int IDX_W    = 3;
  localparam int DIV_W    = 17;
  localparam int XS_W     = DIV_W + 2;

  localparam int MAX_BIN           = 16;
  localparam int MAX_FRAME_DIM     = 4096;
  localparam int MAX_OUT_WIDTH_DEF = 1024;

  localparam int QUEUE_DEPTH = 32;
  localparam int QA_W        = 5;
  localparam int QL_W        = 6;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [IDX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [IDX_W-1:0] REG_BIN_X        = 3'd4;
  localparam logic [IDX_W-1:0] REG_BIN_Y        = 3'd5;
  localparam logic [IDX_W-1:0] REG_OUT_WIDTH    = 3'd6;
  localparam logic [IDX_W-1:0] REG_OUT_HEIGHT   = 3'd7;

  localparam logic [DIM_W-1:0]   RST_FRAME_DIM = 13'd512;
  localparam logic [COORD_W-1:0] RST_CENTER    = 12'd256;
  localparam logic [BIN_W-1:0]   RST_BIN       = 5'd1;
  localparam logic [DIM_W-1:0]   RST_OUT_DIM   = 13'd512;

  typedef struct packed {
    logic [DIM_W-1:0]   fw;
    logic [DIM_W-1:0]   fh;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [BIN_W-1:0]   bx;
    logic [BIN_W-1:0]   by;
    logic [DIM_W-1:0]   ow;
    logic [DIM_W-1:0]   oh;
  } rcb_cfg_t;

  typedef struct packed {
    logic               pass;
    logic               acc;
    logic               tail;
    logic               last;
    logic               fresh;
    logic               clear;
    logic               fd;
    logic [PIX_W-1:0]   px;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } rcb_item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

// ===== rtl/rcb_div.sv =====
// Pipelined restoring divider for the ROI crop and pixel binning block.
// Retires one quotient bit per stage and carries the divisor along.
// Depends on rcb_pkg.
module rcb_div (
  input  logic                       clk,
  input  logic [rcb_pkg::DIV_W-1:0]  num_i,
  input  logic [rcb_pkg::BIN_W-1:0]  den_i,
  output logic [rcb_pkg::DIV_W-1:0]  quo_o,
  output logic [rcb_pkg::REM_W-1:0]  rem_o,
  output logic [rcb_pkg::BIN_W-1:0]  den_o
);

  logic [rcb_pkg::DIV_W-1:0] work_r   [rcb_pkg::DIV_W];
  logic [rcb_pkg::DIV_W-1:0] work_nxt [rcb_pkg::DIV_W];
  logic [rcb_pkg::REM_W-1:0] rem_r    [rcb_pkg::DIV_W];
  logic [rcb_pkg::REM_W-1:0] rem_nxt  [rcb_pkg::DIV_W];
  logic [rcb_pkg::BIN_W-1:0] den_r    [rcb_pkg::DIV_W];
  logic [rcb_pkg::BIN_W-1:0] den_nxt  [rcb_pkg::DIV_W];

  always_comb begin
    logic [rcb_pkg::DIV_W-1:0] w;
    logic [rcb_pkg::REM_W-1:0] rm;
    logic [rcb_pkg::BIN_W-1:0] d;
    logic [rcb_pkg::REM_W:0]   t;
    logic                      ge;
    for (int i = 0; i < rcb_pkg::DIV_W; i++) begin
      if (i == 0) begin
        w  = num_i;
        rm = '0;
        d  = den_i;
      end else begin
        w  = work_r[i-1];
        rm = rem_r[i-1];
        d  = den_r[i-1];
      end
      t  = {rm, w[rcb_pkg::DIV_W-1]};
      ge = ({1'b0, t} >= {1'b0, d});
      rem_nxt[i]  = ge ? rcb_pkg::REM_W'(t - d) : t[rcb_pkg::REM_W-1:0];
      work_nxt[i] = {w[rcb_pkg::DIV_W-2:0], ge};
      den_nxt[i]  = d;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rcb_pkg::DIV_W; i++) begin
      work_r[i] <= work_nxt[i];
      rem_r[i]  <= rem_nxt[i];
      den_r[i]  <= den_nxt[i];
    end
  end

  assign quo_o = work_r[rcb_pkg::DIV_W-1];
  assign rem_o = rem_r[rcb_pkg::DIV_W-1];
  assign den_o = den_r[rcb_pkg::DIV_W-1];

endmodule

// ===== rtl/rcb_front.sv =====
// Front end of the ROI crop and pixel binning block: pixel position counters,
// region test, and bin coordinates through two pipelined dividers.
// Depends on rcb_pkg and rcb_div.
module rcb_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rcb_pkg::rcb_cfg_t          cfg,
  input  logic                       in_acc,
  input  logic [rcb_pkg::PIX_W-1:0]  in_pixel,
  output logic                       push_o,
  output rcb_pkg::rcb_item_t         item_o
);

  typedef struct packed {
    logic                        pass;
    logic                        fd;
    logic                        inreg;
    logic                        c0;
    logic                        r0;
    logic [rcb_pkg::PIX_W-1:0]   px;
    logic [rcb_pkg::COORD_W-1:0] c;
    logic [rcb_pkg::COORD_W-1:0] r;
  } rcb_side_t;

  logic [rcb_pkg::COORD_W-1:0] col_r, col_nxt;
  logic [rcb_pkg::COORD_W-1:0] row_r, row_nxt;
  logic                        col_end, row_end;

  logic [rcb_pkg::DIV_W-1:0]   spanx_r, spany_r;
  logic                        pass_r;

  logic                        s1_v_r;
  logic [rcb_pkg::PIX_W-1:0]   s1_px_r;
  logic [rcb_pkg::COORD_W-1:0] s1_c_r, s1_r_r;
  logic                        s1_fd_r;

  logic                        s2_v_r;
  rcb_side_t                   s2_side_r, s2_side_nxt;
  logic [rcb_pkg::DIV_W-1:0]   s2_dx_r, s2_dy_r;
  logic [rcb_pkg::BIN_W-1:0]   s2_bx_r, s2_by_r;

  logic [rcb_pkg::XS_W-1:0]    dxs, dys;
  logic                        inreg_x, inreg_y, fd_bin;

  logic                        sb_v_r    [rcb_pkg::DIV_W];
  rcb_side_t                   sb_side_r [rcb_pkg::DIV_W];

  logic [rcb_pkg::DIV_W-1:0]   qx, qy;
  logic [rcb_pkg::REM_W-1:0]   remx, remy;
  logic [rcb_pkg::BIN_W-1:0]   bxo, byo;
  rcb_side_t                   so;

  assign col_end = ({1'b0, col_r} + rcb_pkg::DIM_W'(1)) >= cfg.fw;
  assign row_end = ({1'b0, row_r} + rcb_pkg::DIM_W'(1)) >= cfg.fh;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + rcb_pkg::COORD_W'(1);
      end else begin
        col_nxt = col_r + rcb_pkg::COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    spanx_r <= rcb_pkg::DIV_W'(cfg.bx) * rcb_pkg::DIV_W'(cfg.ow);
    spany_r <= rcb_pkg::DIV_W'(cfg.by) * rcb_pkg::DIV_W'(cfg.oh);
    pass_r  <= (cfg.ow == cfg.fw) && (cfg.oh == cfg.fh);
    s1_px_r <= in_pixel;
    s1_c_r  <= col_r;
    s1_r_r  <= row_r;
    s1_fd_r <= col_end && row_end;
  end

  always_comb begin
    dxs = rcb_pkg::XS_W'(spanx_r >> 1) + rcb_pkg::XS_W'(s1_c_r) - rcb_pkg::XS_W'(cfg.cx);
    dys = rcb_pkg::XS_W'(spany_r >> 1) + rcb_pkg::XS_W'(s1_r_r) - rcb_pkg::XS_W'(cfg.cy);
    inreg_x = !dxs[rcb_pkg::XS_W-1] && (dxs[rcb_pkg::XS_W-2:0] < {1'b0, spanx_r});
    inreg_y = !dys[rcb_pkg::XS_W-1] && (dys[rcb_pkg::XS_W-2:0] < {1'b0, spany_r});
    fd_bin  = (dxs[rcb_pkg::DIV_W-1:0] >= spanx_r - rcb_pkg::DIV_W'(cfg.bx)) &&
              (dys[rcb_pkg::DIV_W-1:0] >= spany_r - rcb_pkg::DIV_W'(cfg.by));
    s2_side_nxt.pass  = pass_r;
    s2_side_nxt.fd    = pass_r ? s1_fd_r : fd_bin;
    s2_side_nxt.inreg = inreg_x && inreg_y;
    s2_side_nxt.c0    = (s1_c_r == '0);
    s2_side_nxt.r0    = (s1_r_r == '0);
    s2_side_nxt.px    = s1_px_r;
    s2_side_nxt.c     = s1_c_r;
    s2_side_nxt.r     = s1_r_r;
  end

  always_ff @(posedge clk) begin
    s2_side_r <= s2_side_nxt;
    s2_dx_r   <= dxs[rcb_pkg::DIV_W-1:0];
    s2_dy_r   <= dys[rcb_pkg::DIV_W-1:0];
    s2_bx_r   <= cfg.bx;
    s2_by_r   <= cfg.by;
  end

  rcb_div u_div_x (
    .clk   (clk),
    .num_i (s2_dx_r),
    .den_i (s2_bx_r),
    .quo_o (qx),
    .rem_o (remx),
    .den_o (bxo)
  );

  rcb_div u_div_y (
    .clk   (clk),
    .num_i (s2_dy_r),
    .den_i (s2_by_r),
    .quo_o (qy),
    .rem_o (remy),
    .den_o (byo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rcb_pkg::DIV_W; i++) begin
        sb_v_r[i] <= 1'b0;
      end
    end else begin
      sb_v_r[0] <= s2_v_r;
      for (int i = 1; i < rcb_pkg::DIV_W; i++) begin
        sb_v_r[i] <= sb_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    sb_side_r[0] <= s2_side_r;
    for (int i = 1; i < rcb_pkg::DIV_W; i++) begin
      sb_side_r[i] <= sb_side_r[i-1];
    end
  end

  assign so     = sb_side_r[rcb_pkg::DIV_W-1];
  assign push_o = sb_v_r[rcb_pkg::DIV_W-1];

  always_comb begin
    item_o.pass  = so.pass;
    item_o.acc   = so.inreg && !so.pass;
    item_o.tail  = ({1'b0, remx} == bxo - rcb_pkg::BIN_W'(1));
    item_o.last  = ({1'b0, remy} == byo - rcb_pkg::BIN_W'(1));
    item_o.fresh = (remy == '0) || so.r0;
    item_o.clear = (remx == '0) || so.c0;
    item_o.fd    = so.fd;
    item_o.px    = so.px;
    item_o.col   = so.pass ? so.c : qx[rcb_pkg::COORD_W-1:0];
    item_o.row   = so.pass ? so.r : qy[rcb_pkg::COORD_W-1:0];
  end

endmodule

// ===== rtl/rcb_fifo.sv =====
// Queue between the front and back ends of the ROI crop and pixel binning block.
// First-word-fall-through register queue of classified items; depends on rcb_pkg.
module rcb_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  rcb_pkg::rcb_item_t        din,
  input  logic                      pop,
  output rcb_pkg::rcb_item_t        dout,
  output logic [rcb_pkg::QL_W-1:0]  level
);

  rcb_pkg::rcb_item_t          mem_r [rcb_pkg::QUEUE_DEPTH];
  logic [rcb_pkg::QA_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [rcb_pkg::QL_W-1:0]    level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    unique case ({push, pop})
      2'b10:   level_nxt = level_r + rcb_pkg::QL_W'(1);
      2'b01:   level_nxt = level_r - rcb_pkg::QL_W'(1);
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + rcb_pkg::QA_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + rcb_pkg::QA_W'(1);
      end
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign level = level_r;

endmodule

// ===== rtl/rcb_back.sv =====
// Back end of the ROI crop and pixel binning block: running bin sum, line
// memory of partial sums with write forwarding, and the output register.
// Depends on rcb_pkg.
module rcb_back #(
  parameter int MAX_OUT_WIDTH = rcb_pkg::MAX_OUT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  rcb_pkg::rcb_item_t           q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rcb_pkg::SUM_W-1:0]    out_bin_sum,
  output logic [rcb_pkg::COORD_W-1:0]  out_col,
  output logic [rcb_pkg::COORD_W-1:0]  out_row,
  output logic                         out_frame_done
);

  localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

  logic [rcb_pkg::SUM_W-1:0]   psum_mem [MAX_OUT_WIDTH];

  logic                        b1_v_r;
  rcb_pkg::rcb_item_t          b1_r;
  logic [rcb_pkg::SUM_W-1:0]   run_r, run_nxt;
  logic [rcb_pkg::SUM_W-1:0]   rd_r;
  logic                        fwd_v_r;
  logic [rcb_pkg::SUM_W-1:0]   fwd_d_r;

  logic [rcb_pkg::SUM_W-1:0]   prev, sum;
  logic                        do_tail, emit, wr, out_free, fire;
  logic [AW-1:0]               raddr, waddr;

  logic                        out_v_r;
  logic [rcb_pkg::SUM_W-1:0]   out_sum_r;
  logic [rcb_pkg::COORD_W-1:0] out_col_r, out_row_r;
  logic                        out_fd_r;

  assign raddr = q_item.col[AW-1:0];
  assign waddr = b1_r.col[AW-1:0];

  always_comb begin
    prev     = b1_r.fresh ? '0 : (fwd_v_r ? fwd_d_r : rd_r);
    sum      = prev + run_r;
    do_tail  = b1_v_r && b1_r.acc && b1_r.tail;
    emit     = b1_v_r && (b1_r.pass || (do_tail && b1_r.last));
    wr       = do_tail && !b1_r.last;
    out_free = !out_v_r || !out_stall;
    fire     = emit && out_free;
    q_pop    = q_valid && (!emit || out_free);
    run_nxt  = run_r;
    if (q_pop && q_item.acc) begin
      run_nxt = (q_item.clear ? '0 : run_r) + rcb_pkg::SUM_W'(q_item.px);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      run_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        b1_v_r <= 1'b1;
      end else if (!emit || out_free) begin
        b1_v_r <= 1'b0;
      end
      run_r <= run_nxt;
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_r    <= q_item;
      rd_r    <= psum_mem[raddr];
      fwd_v_r <= wr && (waddr == raddr);
      fwd_d_r <= sum;
    end
    if (wr) begin
      psum_mem[waddr] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_sum_r <= b1_r.pass ? rcb_pkg::SUM_W'(b1_r.px) : sum;
      out_col_r <= b1_r.col;
      out_row_r <= b1_r.row;
      out_fd_r  <= b1_r.fd;
    end
  end

  assign out_valid      = out_v_r;
  assign out_bin_sum    = out_sum_r;
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_frame_done = out_fd_r;

endmodule

// ===== rtl/roi_crop_and_pixel_binning.sv =====
// ROI crop and pixel binning, top level: configuration registers, credit count.
// One pixel per cycle is taken while in_stall is low. Bin column and row come from
// two 17-stage pipelined dividers. A 32-entry queue and a credit count let pixels in
// while the output stalls, until all 32 credits are taken and in_stall rises.
// Reset (synchronous, rst_n low) restores default registers and clears counters and sums;
// the partial-sum line memory is not cleared and holds no valid data until written.
module roi_crop_and_pixel_binning #(
  parameter int MAX_OUT_WIDTH = rcb_pkg::MAX_OUT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rcb_pkg::PIX_W-1:0]    in_pixel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rcb_pkg::SUM_W-1:0]    out_bin_sum,
  output logic [rcb_pkg::COORD_W-1:0]  out_col,
  output logic [rcb_pkg::COORD_W-1:0]  out_row,
  output logic                         out_frame_done,
  input  logic                         cfg_wr_en,
  input  logic [rcb_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rcb_pkg::REG_W-1:0]    cfg_wdata
);

  localparam logic [rcb_pkg::DIM_W-1:0] OW_MAX = rcb_pkg::DIM_W'(MAX_OUT_WIDTH);
  localparam logic [rcb_pkg::DIM_W-1:0] FD_MAX = rcb_pkg::DIM_W'(rcb_pkg::MAX_FRAME_DIM);
  localparam logic [rcb_pkg::DIM_W-1:0] BN_MAX = rcb_pkg::DIM_W'(rcb_pkg::MAX_BIN);

  rcb_pkg::rcb_cfg_t           cfg_r, cfg_nxt;
  logic [rcb_pkg::QL_W-1:0]    cnt_r, cnt_nxt;
  logic                        in_acc;
  logic                        q_push, q_pop;
  rcb_pkg::rcb_item_t          q_din, q_dout;
  logic [rcb_pkg::QL_W-1:0]    q_level;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        rcb_pkg::REG_FRAME_WIDTH:  cfg_nxt.fw = rcb_pkg::clamp_dim(cfg_wdata, FD_MAX);
        rcb_pkg::REG_FRAME_HEIGHT: cfg_nxt.fh = rcb_pkg::clamp_dim(cfg_wdata, FD_MAX);
        rcb_pkg::REG_CENTER_X:     cfg_nxt.cx = cfg_wdata[rcb_pkg::COORD_W-1:0];
        rcb_pkg::REG_CENTER_Y:     cfg_nxt.cy = cfg_wdata[rcb_pkg::COORD_W-1:0];
        rcb_pkg::REG_BIN_X:        cfg_nxt.bx = rcb_pkg::BIN_W'(rcb_pkg::clamp_dim(
                                     rcb_pkg::DIM_W'(cfg_wdata[rcb_pkg::BIN_W-1:0]), BN_MAX));
        rcb_pkg::REG_BIN_Y:        cfg_nxt.by = rcb_pkg::BIN_W'(rcb_pkg::clamp_dim(
                                     rcb_pkg::DIM_W'(cfg_wdata[rcb_pkg::BIN_W-1:0]), BN_MAX));
        rcb_pkg::REG_OUT_WIDTH:    cfg_nxt.ow = rcb_pkg::clamp_dim(
                                     rcb_pkg::DIM_W'(cfg_wdata[10:0]), OW_MAX);
        rcb_pkg::REG_OUT_HEIGHT:   cfg_nxt.oh = rcb_pkg::clamp_dim(cfg_wdata, FD_MAX);
      endcase
    end
  end

  assign in_stall = (cnt_r == rcb_pkg::QL_W'(rcb_pkg::QUEUE_DEPTH));
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    unique case ({in_acc, q_pop})
      2'b10:   cnt_nxt = cnt_r + rcb_pkg::QL_W'(1);
      2'b01:   cnt_nxt = cnt_r - rcb_pkg::QL_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fw <= rcb_pkg::RST_FRAME_DIM;
      cfg_r.fh <= rcb_pkg::RST_FRAME_DIM;
      cfg_r.cx <= rcb_pkg::RST_CENTER;
      cfg_r.cy <= rcb_pkg::RST_CENTER;
      cfg_r.bx <= rcb_pkg::RST_BIN;
      cfg_r.by <= rcb_pkg::RST_BIN;
      cfg_r.ow <= rcb_pkg::clamp_dim(rcb_pkg::RST_OUT_DIM, OW_MAX);
      cfg_r.oh <= rcb_pkg::RST_OUT_DIM;
      cnt_r    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  rcb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_acc   (in_acc),
    .in_pixel (in_pixel),
    .push_o   (q_push),
    .item_o   (q_din)
  );

  rcb_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .level (q_level)
  );

  rcb_back #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_level != '0),
    .q_item         (q_dout),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bin_sum    (out_bin_sum),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_frame_done (out_frame_done)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_level < rcb_pkg::QL_W'(rcb_pkg::QUEUE_DEPTH)))
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_level != '0))
    else $error("Queue read while empty.");

  a_credit_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (cnt_r != '0))
    else $error("Credit count empty right after an input transfer.");

  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid set right after reset.");

endmodule

// ===== tb/roi_bin_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the ROI crop and pixel binning block: it watches the pixel, result
// and register ports, predicts every result and compares it with what the block sends.
// Depends on rcb_pkg for field widths, register indexes and reset values.
module roi_bin_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [rcb_pkg::PIX_W-1:0]    in_pixel,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [rcb_pkg::SUM_W-1:0]    out_bin_sum,
  input  logic [rcb_pkg::COORD_W-1:0]  out_col,
  input  logic [rcb_pkg::COORD_W-1:0]  out_row,
  input  logic                         out_frame_done,
  input  logic                         cfg_wr_en,
  input  logic [rcb_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rcb_pkg::REG_W-1:0]    cfg_wdata,
  output int                           mismatches,
  output int                           pending,
  output int                           checked
);

  localparam int LINE_DEPTH = rcb_pkg::MAX_OUT_WIDTH_DEF;

  typedef struct packed {
    logic [rcb_pkg::SUM_W-1:0]   sum;
    logic [rcb_pkg::COORD_W-1:0] col;
    logic [rcb_pkg::COORD_W-1:0] row;
    logic                        done;
  } bin_out_t;

  logic [rcb_pkg::DIM_W-1:0]   reg_fw;
  logic [rcb_pkg::DIM_W-1:0]   reg_fh;
  logic [rcb_pkg::COORD_W-1:0] reg_cx;
  logic [rcb_pkg::COORD_W-1:0] reg_cy;
  logic [rcb_pkg::BIN_W-1:0]   reg_bx;
  logic [rcb_pkg::BIN_W-1:0]   reg_by;
  logic [10:0]                 reg_ow;
  logic [rcb_pkg::DIM_W-1:0]   reg_oh;

  int                        col_q;
  int                        row_q;
  logic [rcb_pkg::SUM_W-1:0] run_sum;
  logic [rcb_pkg::SUM_W-1:0] line_sums [LINE_DEPTH];
  bin_out_t                  due_bins [$];

  initial begin
    mismatches = 0;
    checked = 0;
    pending = 0;
  end

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the pixel position and returns 1 when this pixel completes a result.
  function automatic bit bin_pixel(input logic [rcb_pkg::PIX_W-1:0] px, output bin_out_t res);
    int fw, fh, ow, oh, bx, by, c, r, spanx, spany, dx, dy, bc, br, sub_c, sub_r;
    bit col_end, row_end, emit;
    logic [rcb_pkg::SUM_W-1:0] prev;
    fw = clip(int'(reg_fw), 1, rcb_pkg::MAX_FRAME_DIM);
    fh = clip(int'(reg_fh), 1, rcb_pkg::MAX_FRAME_DIM);
    ow = clip(int'(reg_ow), 1, LINE_DEPTH);
    oh = clip(int'(reg_oh), 1, rcb_pkg::MAX_FRAME_DIM);
    bx = clip(int'(reg_bx), 1, rcb_pkg::MAX_BIN);
    by = clip(int'(reg_by), 1, rcb_pkg::MAX_BIN);
    c = col_q;
    r = row_q;
    col_end = (c + 1 >= fw);
    row_end = (r + 1 >= fh);
    emit = 1'b0;
    res = '0;
    if (ow == fw && oh == fh) begin
      res.sum = rcb_pkg::SUM_W'(px);
      res.col = rcb_pkg::COORD_W'(c);
      res.row = rcb_pkg::COORD_W'(r);
      res.done = col_end && row_end;
      emit = 1'b1;
    end else begin
      spanx = bx * ow;
      spany = by * oh;
      dx = c - (int'(reg_cx) - spanx / 2);
      dy = r - (int'(reg_cy) - spany / 2);
      if (dx >= 0 && dx < spanx && dy >= 0 && dy < spany) begin
        bc = dx / bx;
        br = dy / by;
        sub_c = dx % bx;
        sub_r = dy % by;
        if (sub_c == 0 || c == 0) begin
          run_sum = '0;
        end
        run_sum = run_sum + px;
        if (sub_c == bx - 1 && bc < LINE_DEPTH) begin
          prev = (sub_r == 0 || r == 0) ? '0 : line_sums[bc];
          if (sub_r == by - 1) begin
            res.sum = prev + run_sum;
            res.col = rcb_pkg::COORD_W'(bc);
            res.row = rcb_pkg::COORD_W'(br);
            res.done = (bc == ow - 1 && br == oh - 1);
            emit = 1'b1;
          end else begin
            line_sums[bc] = prev + run_sum;
          end
        end
      end
    end
    if (col_end) begin
      col_q = 0;
      row_q = row_end ? 0 : r + 1;
    end else begin
      col_q = c + 1;
    end
    return emit;
  endfunction

  always @(posedge clk) begin
    bin_out_t want;
    bin_out_t got;
    if (!rst_n) begin
      reg_fw = rcb_pkg::RST_FRAME_DIM;
      reg_fh = rcb_pkg::RST_FRAME_DIM;
      reg_cx = rcb_pkg::RST_CENTER;
      reg_cy = rcb_pkg::RST_CENTER;
      reg_bx = rcb_pkg::RST_BIN;
      reg_by = rcb_pkg::RST_BIN;
      reg_ow = 11'(rcb_pkg::RST_OUT_DIM);
      reg_oh = rcb_pkg::RST_OUT_DIM;
      col_q = 0;
      row_q = 0;
      run_sum = '0;
      due_bins.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rcb_pkg::REG_FRAME_WIDTH:  reg_fw = cfg_wdata;
          rcb_pkg::REG_FRAME_HEIGHT: reg_fh = cfg_wdata;
          rcb_pkg::REG_CENTER_X:     reg_cx = cfg_wdata[rcb_pkg::COORD_W-1:0];
          rcb_pkg::REG_CENTER_Y:     reg_cy = cfg_wdata[rcb_pkg::COORD_W-1:0];
          rcb_pkg::REG_BIN_X:        reg_bx = cfg_wdata[rcb_pkg::BIN_W-1:0];
          rcb_pkg::REG_BIN_Y:        reg_by = cfg_wdata[rcb_pkg::BIN_W-1:0];
          rcb_pkg::REG_OUT_WIDTH:    reg_ow = cfg_wdata[10:0];
          rcb_pkg::REG_OUT_HEIGHT:   reg_oh = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (bin_pixel(in_pixel, want)) begin
          due_bins.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        got = {out_bin_sum, out_col, out_row, out_frame_done};
        checked++;
        if (due_bins.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual sum %0d col %0d row %0d done %0b",
                   $time, got.sum, got.col, got.row, got.done);
          mismatches++;
        end else begin
          want = due_bins.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected sum %0d col %0d row %0d done %0b,",
                     $time, want.sum, want.col, want.row, want.done);
            $display("  actual sum %0d col %0d row %0d done %0b",
                     got.sum, got.col, got.row, got.done);
            mismatches++;
          end
        end
      end
    end
    pending = due_bins.size();
  end

endmodule

// ===== tb/roi_crop_and_pixel_binning_tb.sv =====
`timescale 1ns / 100ps
// Top of the ROI crop and pixel binning testbench: clock, reset, pixel and register
// stimulus, output back-pressure and the verdict. Checking is done in roi_bin_checker.
// Depends on rcb_pkg, roi_crop_and_pixel_binning and roi_bin_checker.
module roi_crop_and_pixel_binning_tb;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int WIDE_ITEMS   = 64;
  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_ITEMS  = 150;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [rcb_pkg::PIX_W-1:0]    in_pixel;
  logic                         out_valid;
  logic                         out_stall;
  logic [rcb_pkg::SUM_W-1:0]    out_bin_sum;
  logic [rcb_pkg::COORD_W-1:0]  out_col;
  logic [rcb_pkg::COORD_W-1:0]  out_row;
  logic                         out_frame_done;
  logic                         cfg_wr_en;
  logic [rcb_pkg::IDX_W-1:0]    cfg_index;
  logic [rcb_pkg::REG_W-1:0]    cfg_wdata;

  int mismatches;
  int pending;
  int checked;

  int sent;
  int settings;
  int pos_c;
  int pos_r;
  int eff_w;
  int eff_h;
  bit tx_gaps;
  bit rx_gaps;
  bit hold_req;
  bit all_ones;

  roi_crop_and_pixel_binning dut (.*);

  roi_bin_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d results still expected.", CYCLE_LIMIT, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side back-pressure: random stall bursts, plus one long hold on request.
  initial begin
    int span;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 19);
        repeat (span) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int dim_limit(input int v);
    if (v == 0) return 1;
    if (v > rcb_pkg::MAX_FRAME_DIM) return rcb_pkg::MAX_FRAME_DIM;
    return v;
  endfunction

  function automatic logic [rcb_pkg::PIX_W-1:0] any_pixel();
    if (all_ones) return '1;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return rcb_pkg::PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [rcb_pkg::PIX_W-1:0] px);
    int gap;
    @(negedge clk);
    if (tx_gaps && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (pos_c + 1 >= eff_w) begin
      pos_c = 0;
      pos_r = (pos_r + 1 >= eff_h) ? 0 : pos_r + 1;
    end else begin
      pos_c++;
    end
  endtask

  task automatic finish_frame();
    while (pos_c != 0 || pos_r != 0) send_pixel(any_pixel());
  endtask

  task automatic send_frames(input int n);
    repeat (n) begin
      send_pixel(any_pixel());
      finish_frame();
    end
  endtask

  // Waits until every expected result has arrived and the pipeline has emptied.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [rcb_pkg::IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= rcb_pkg::REG_W'(val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == rcb_pkg::REG_FRAME_WIDTH) eff_w = dim_limit(val % 8192);
    if (idx == rcb_pkg::REG_FRAME_HEIGHT) eff_h = dim_limit(val % 8192);
  endtask

  task automatic set_cfg(input int fw, input int fh, input int cx, input int cy,
                         input int bx, input int by, input int ow, input int oh);
    settle();
    cfg_write(rcb_pkg::REG_FRAME_WIDTH, fw);
    cfg_write(rcb_pkg::REG_FRAME_HEIGHT, fh);
    cfg_write(rcb_pkg::REG_CENTER_X, cx);
    cfg_write(rcb_pkg::REG_CENTER_Y, cy);
    cfg_write(rcb_pkg::REG_BIN_X, bx);
    cfg_write(rcb_pkg::REG_BIN_Y, by);
    cfg_write(rcb_pkg::REG_OUT_WIDTH, ow);
    cfg_write(rcb_pkg::REG_OUT_HEIGHT, oh);
    settings++;
  endtask

  // Small random geometry: mostly a region inside the frame, sometimes one cut by
  // the frame edges, sometimes pass-through. Unit sizes are at times written as zero.
  task automatic random_setup();
    int bx, by, ow, oh, fw, fh, cx, cy;
    bx = $urandom_range(1, 4);
    by = $urandom_range(1, 4);
    ow = $urandom_range(1, 6);
    oh = $urandom_range(1, 4);
    fw = bx * ow + $urandom_range(0, 6);
    fh = by * oh + $urandom_range(0, 3);
    cx = bx * ow / 2 + $urandom_range(0, fw - bx * ow);
    cy = by * oh / 2 + $urandom_range(0, fh - by * oh);
    case ($urandom_range(0, 4))
      0: begin
        cx = $urandom_range(0, fw + 3);
        cy = $urandom_range(0, fh + 3);
      end
      1: begin
        ow = fw;
        oh = fh;
      end
      default: ;
    endcase
    if (bx == 1 && $urandom_range(0, 1) == 1) bx = 0;
    if (by == 1 && $urandom_range(0, 1) == 1) by = 0;
    if (ow == 1 && $urandom_range(0, 1) == 1) ow = 0;
    if (oh == 1 && $urandom_range(0, 1) == 1) oh = 0;
    if (fw == 1 && $urandom_range(0, 1) == 1) fw = 0;
    if (fh == 1 && $urandom_range(0, 1) == 1) fh = 0;
    set_cfg(fw, fh, cx, cy, bx, by, ow, oh);
  endtask

  initial begin
    int first;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel = '0;
    cfg_wr_en = 1'b0;
    cfg_index = rcb_pkg::REG_FRAME_WIDTH;
    cfg_wdata = '0;
    sent = 0;
    settings = 1;
    pos_c = 0;
    pos_r = 0;
    eff_w = int'(rcb_pkg::RST_FRAME_DIM);
    eff_h = int'(rcb_pkg::RST_FRAME_DIM);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    hold_req = 1'b0;
    all_ones = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings pass pixels through; then the frame shrinks under the column counter.
    send_pixel('0);
    send_pixel('1);
    send_pixel(16'h5555);
    send_pixel(16'hAAAA);
    send_pixel(16'h0001);
    settle();
    cfg_write(rcb_pkg::REG_FRAME_WIDTH, 4);
    cfg_write(rcb_pkg::REG_FRAME_HEIGHT, 2);
    cfg_write(rcb_pkg::REG_OUT_WIDTH, 4);
    cfg_write(rcb_pkg::REG_OUT_HEIGHT, 2);
    settings++;
    finish_frame();

    // One 2x2 bin inside a 4x2 frame.
    set_cfg(4, 2, 2, 1, 2, 2, 1, 1);
    send_frames(1);

    // Largest bin of saturated pixels gives the largest sum.
    set_cfg(16, 16, 8, 8, 16, 16, 1, 1);
    all_ones = 1'b1;
    send_frames(1);
    all_ones = 1'b0;

    // Widest frame and oversized bin and output width registers, region cut on the left.
    // The start of the row is sent, then the frame narrows under the column counter.
    set_cfg(8191, 1, 4095, 0, 31, 1, 8191, 1);
    repeat (WIDE_ITEMS) send_pixel(any_pixel());
    settle();
    cfg_write(rcb_pkg::REG_FRAME_WIDTH, 4);
    settings++;
    finish_frame();

    // Single-column frame, zero sizes clamped up, oversized vertical bin, bottom cut.
    set_cfg(0, 40, 0, 39, 0, 20, 1, 3);
    send_frames(1);

    // Oversized output height clamped, region cut at the top.
    set_cfg(12, 10, 6, 3, 3, 2, 2, 8191);
    send_frames(1);

    // The frame shrinks under the row counter.
    set_cfg(6, 6, 0, 0, 1, 1, 6, 6);
    repeat (24) send_pixel(any_pixel());
    settle();
    cfg_write(rcb_pkg::REG_FRAME_HEIGHT, 3);
    cfg_write(rcb_pkg::REG_OUT_HEIGHT, 3);
    settings++;
    finish_frame();

    // Long output hold while pixels keep coming, so the block fills and stalls its input.
    set_cfg(32, 4, 0, 0, 1, 1, 32, 4);
    hold_req = 1'b1;
    send_frames(1);

    first = sent;
    while (sent - first < RANDOM_ITEMS) begin
      if (sent - first >= RANDOM_ITEMS - QUIET_ITEMS) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      random_setup();
      send_frames($urandom_range(1, 2));
    end

    settle();
    $display("Covered %0d pixel transfers over %0d register settings: pass-through, binned and",
             sent, settings);
    $display("edge-cut regions, clamped registers, counter wrap and a long hold; %0d results checked.",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
